/* src/llcp_pkg.sv */
// ----------------------------------------------------------------------------
// llcp_pkg
// Shared constants and item types for the line-line closest point pipeline.
// ----------------------------------------------------------------------------
package llcp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QB        = 31;
  localparam int NUM_W     = 90;
  localparam int DEN_W     = 72;
  localparam int SH_W      = NUM_W + FRAC_BITS;

  localparam logic [31:0] EPS_RESET = 32'd4295;

  typedef struct packed {
    logic [2:0][31:0] o1;
    logic [2:0][31:0] o2;
    logic [2:0][17:0] d1;
    logic [2:0][17:0] d2;
  } side_t;

  typedef struct packed {
    logic [SH_W-1:0]  rem;
    logic [DEN_W-1:0] den;
    logic [QB-1:0]    q;
    logic             neg;
    logic             zero;
    logic             ovf;
  } div_lane_t;

  typedef struct packed {
    div_lane_t s;
    div_lane_t t;
    side_t     side;
    logic      par;
    logic      degen;
  } div_t;

  typedef struct packed {
    logic [31:0]      offset1;
    logic [31:0]      offset2;
    logic [2:0][31:0] c1;
    logic [2:0][31:0] c2;
    logic             par;
    logic             degen;
  } tail_t;

endpackage

/* src/llcp_front.sv */
// ----------------------------------------------------------------------------
// llcp_front
// Dot products, Gram determinant, offset numerators and divider setup.
// ----------------------------------------------------------------------------
module llcp_front import llcp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        ce,
  input  logic        in_valid,
  input  side_t       in_side,
  input  logic [31:0] eps,
  output logic        out_valid,
  output div_t        out_item
);

  logic [7:0] vld;
  side_t      sd [7];

  logic signed [32:0] df1 [3];
  logic signed [35:0] aa2 [3];
  logic signed [35:0] bb2 [3];
  logic signed [35:0] pd2 [3];
  logic signed [50:0] e1_2 [3];
  logic signed [50:0] e2_2 [3];

  logic [35:0]        a00_3, a11_3;
  logic signed [36:0] p3;
  logic signed [51:0] b0_3, qd3;

  logic [53:0]        x_lo, x_hi, y_lo, y_hi;
  logic signed [63:0] ps_lo, ab_lo, aq_lo, pb_lo;
  logic signed [62:0] ps_hi, ab_hi, aq_hi, pb_hi;
  logic [35:0]        a00_4;
  logic signed [51:0] b0_4;
  logic               degen4;

  logic [71:0]        x5, y5;
  logic signed [89:0] nums5, numt5;
  logic [35:0]        a00_5;
  logic signed [51:0] b0_5;
  logic               degen5;

  logic [71:0]        det6;
  logic signed [89:0] nums6, numt6;
  logic [35:0]        a00_6;
  logic signed [51:0] b0_6;
  logic               degen6;

  logic signed [89:0] nums7, numt7;
  logic [71:0]        dens7, dent7;
  logic               zs7, zt7, par7, degen7;

  logic [35:0]        pm4;
  logic signed [36:0] a00s, a11s;
  logic signed [26:0] qd_lo, b0_lo;
  logic signed [25:0] qd_hi, b0_hi;
  logic [71:0]        thr;
  logic               par_c;

  function automatic div_lane_t mk_lane(logic signed [89:0] num, logic [71:0] den,
                                        logic zero);
    div_lane_t  r;
    logic [89:0] mag;
    mag    = num[89] ? 90'(-num) : 90'(num);
    r.rem  = SH_W'(mag) << FRAC_BITS;
    r.den  = den;
    r.q    = '0;
    r.neg  = num[89];
    r.zero = zero;
    r.ovf  = 1'b0;
    return r;
  endfunction

  always_comb begin
    pm4   = 36'(p3[36] ? -p3 : p3);
    a00s  = $signed({1'b0, a00_3});
    a11s  = $signed({1'b0, a11_3});
    qd_lo = $signed({1'b0, qd3[25:0]});
    qd_hi = qd3[51:26];
    b0_lo = $signed({1'b0, b0_3[25:0]});
    b0_hi = b0_3[51:26];
    thr   = 72'(eps) << (2 * FRAC_BITS);
    par_c = degen6 || (det6 == '0) || (det6 < thr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[6:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sd[0] <= in_side;
      for (int j = 1; j < 7; j++) sd[j] <= sd[j-1];

      for (int k = 0; k < 3; k++) begin
        df1[k]  <= $signed({in_side.o1[k][31], in_side.o1[k]})
                 - $signed({in_side.o2[k][31], in_side.o2[k]});
        aa2[k]  <= $signed(sd[0].d1[k]) * $signed(sd[0].d1[k]);
        bb2[k]  <= $signed(sd[0].d2[k]) * $signed(sd[0].d2[k]);
        pd2[k]  <= $signed(sd[0].d1[k]) * $signed(sd[0].d2[k]);
        e1_2[k] <= df1[k] * $signed(sd[0].d1[k]);
        e2_2[k] <= df1[k] * $signed(sd[0].d2[k]);
      end

      a00_3 <= 36'(aa2[0] + aa2[1] + aa2[2]);
      a11_3 <= 36'(bb2[0] + bb2[1] + bb2[2]);
      p3    <= 37'(pd2[0]) + 37'(pd2[1]) + 37'(pd2[2]);
      b0_3  <= 52'(e1_2[0]) + 52'(e1_2[1]) + 52'(e1_2[2]);
      qd3   <= 52'(e2_2[0]) + 52'(e2_2[1]) + 52'(e2_2[2]);

      x_lo   <= a00_3 * a11_3[17:0];
      x_hi   <= a00_3 * a11_3[35:18];
      y_lo   <= pm4 * pm4[17:0];
      y_hi   <= pm4 * pm4[35:18];
      ps_lo  <= p3 * qd_lo;
      ps_hi  <= p3 * qd_hi;
      ab_lo  <= a11s * b0_lo;
      ab_hi  <= a11s * b0_hi;
      aq_lo  <= a00s * qd_lo;
      aq_hi  <= a00s * qd_hi;
      pb_lo  <= p3 * b0_lo;
      pb_hi  <= p3 * b0_hi;
      a00_4  <= a00_3;
      b0_4   <= b0_3;
      degen4 <= (a00_3 == '0);

      x5     <= 72'(x_lo) + (72'(x_hi) << 18);
      y5     <= 72'(y_lo) + (72'(y_hi) << 18);
      nums5  <= (90'(ps_hi) <<< 26) + 90'(ps_lo) - (90'(ab_hi) <<< 26) - 90'(ab_lo);
      numt5  <= (90'(aq_hi) <<< 26) + 90'(aq_lo) - (90'(pb_hi) <<< 26) - 90'(pb_lo);
      a00_5  <= a00_4;
      b0_5   <= b0_4;
      degen5 <= degen4;

      det6   <= (x5 >= y5) ? x5 - y5 : y5 - x5;
      nums6  <= nums5;
      numt6  <= numt5;
      a00_6  <= a00_5;
      b0_6   <= b0_5;
      degen6 <= degen5;

      nums7  <= degen6 ? '0 : (par_c ? -90'(b0_6) : nums6);
      dens7  <= par_c ? 72'(a00_6) : det6;
      zs7    <= degen6;
      numt7  <= numt6;
      dent7  <= det6;
      zt7    <= par_c;
      par7   <= par_c;
      degen7 <= degen6;

      out_item.s     <= mk_lane(nums7, dens7, zs7);
      out_item.t     <= mk_lane(numt7, dent7, zt7);
      out_item.side  <= sd[6];
      out_item.par   <= par7;
      out_item.degen <= degen7;
    end
  end

  assign out_valid = vld[7];

endmodule

/* src/llcp_div.sv */
// ----------------------------------------------------------------------------
// llcp_div
// Pipelined restoring divider, two lanes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module llcp_div import llcp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic ce,
  input  logic in_valid,
  input  div_t in_item,
  output logic out_valid,
  output div_t out_item
);

  logic [QB:0] vld;
  div_t        stg [QB+1];

  function automatic div_lane_t ovf_chk(div_lane_t l);
    div_lane_t r;
    r     = l;
    r.ovf = (l.rem >= (SH_W'(l.den) << QB));
    return r;
  endfunction

  function automatic div_lane_t step(div_lane_t l, int b);
    div_lane_t       r;
    logic [SH_W-1:0] tr;
    r  = l;
    tr = SH_W'(l.den) << b;
    if (l.rem >= tr) begin
      r.rem = l.rem - tr;
      r.q   = l.q | (QB'(1) << b);
    end
    return r;
  endfunction

  function automatic div_t chk_item(div_t i);
    div_t r;
    r   = i;
    r.s = ovf_chk(i.s);
    r.t = ovf_chk(i.t);
    return r;
  endfunction

  function automatic div_t step_item(div_t i, int b);
    div_t r;
    r   = i;
    r.s = step(i.s, b);
    r.t = step(i.t, b);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[QB-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      stg[0] <= chk_item(in_item);
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_stage
    always_ff @(posedge clk) begin
      if (ce) begin
        stg[j+1] <= step_item(stg[j], QB - 1 - j);
      end
    end
  end

  assign out_valid = vld[QB];
  assign out_item  = stg[QB];

endmodule

/* src/llcp_back.sv */
// ----------------------------------------------------------------------------
// llcp_back
// Offset saturation, closest points and squared distance.
// ----------------------------------------------------------------------------
module llcp_back import llcp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        ce,
  input  logic        in_valid,
  input  div_t        in_item,
  output logic        out_valid,
  output logic [62:0] dist_sq,
  output tail_t       out_tail
);

  logic [6:0] vld;

  side_t              sd1, sd2;
  logic signed [31:0] s1, t1, s2, t2;
  logic               par1, degen1, par2, degen2;

  logic signed [49:0] d1s [3];
  logic signed [49:0] d2t [3];
  logic signed [32:0] df2 [3];
  logic signed [52:0] w3 [3];
  logic [51:0]        m4 [3];
  logic [51:0]        hh [3];
  logic [51:0]        hl [3];
  logic [51:0]        ll [3];
  logic [103:0]       sq [3];
  tail_t              tl [4];

  logic [105:0] sum7;
  logic [73:0]  sh7;

  function automatic logic signed [31:0] lane_res(div_lane_t l);
    logic [31:0] mag;
    mag = {1'b0, l.q};
    if (l.zero) return '0;
    else if (l.ovf) return l.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else return l.neg ? -mag : mag;
  endfunction

  function automatic logic [31:0] sat32(logic signed [34:0] x);
    if (x > 35'sd2147483647) return 32'h7FFF_FFFF;
    else if (x < -35'sd2147483648) return 32'h8000_0000;
    else return x[31:0];
  endfunction

  always_comb begin
    sum7 = 106'(sq[0]) + 106'(sq[1]) + 106'(sq[2]);
    sh7  = 74'(sum7 >> (2 * FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1     <= lane_res(in_item.s);
      t1     <= lane_res(in_item.t);
      sd1    <= in_item.side;
      par1   <= in_item.par;
      degen1 <= in_item.degen;

      s2     <= s1;
      t2     <= t1;
      sd2    <= sd1;
      par2   <= par1;
      degen2 <= degen1;

      tl[0].offset1 <= s2;
      tl[0].offset2 <= t2;
      tl[0].par     <= par2;
      tl[0].degen   <= degen2;

      for (int k = 0; k < 3; k++) begin
        d1s[k] <= $signed(sd1.d1[k]) * s1;
        d2t[k] <= $signed(sd1.d2[k]) * t1;
        df2[k] <= $signed({sd1.o1[k][31], sd1.o1[k]}) - $signed({sd1.o2[k][31], sd1.o2[k]});

        w3[k]       <= (53'(df2[k]) <<< FRAC_BITS) + 53'(d1s[k]) - 53'(d2t[k]);
        tl[0].c1[k] <= sat32(35'($signed(sd2.o1[k])) + 35'(d1s[k] >>> FRAC_BITS));
        tl[0].c2[k] <= sat32(35'($signed(sd2.o2[k])) + 35'(d2t[k] >>> FRAC_BITS));

        m4[k] <= w3[k][52] ? 52'(-w3[k]) : 52'(w3[k]);

        hh[k] <= m4[k][51:26] * m4[k][51:26];
        hl[k] <= m4[k][51:26] * m4[k][25:0];
        ll[k] <= m4[k][25:0] * m4[k][25:0];

        sq[k] <= (104'(hh[k]) << 52) + (104'(hl[k]) << 27) + 104'(ll[k]);
      end

      for (int j = 1; j < 4; j++) tl[j] <= tl[j-1];
      out_tail <= tl[3];
      dist_sq  <= (sh7[73:63] != '0) ? {63{1'b1}} : sh7[62:0];
    end
  end

  assign out_valid = vld[6];

endmodule

/* src/line_line_closest_points_3d_top.sv */
// ----------------------------------------------------------------------------
// line_line_closest_points_3d_top
// Throughput: one item per cycle; the pipeline moves as a whole and holds
// while the result register waits on m_tready (8 setup, 32 divider, 7 tail).
// Reset clears every valid bit and loads the parallel threshold eps with 4295.
// ----------------------------------------------------------------------------
module line_line_closest_points_3d_top import llcp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // origin1_x, origin1_y, origin1_z, dir1_x, dir1_y, dir1_z,
  // origin2_x, origin2_y, origin2_z, dir2_x, dir2_y, dir2_z, zero pad
  input  logic [303:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // dist_sq, offset1, offset2, closest1_x, closest1_y, closest1_z,
  // closest2_x, closest2_y, closest2_z, zero pad
  output logic [319:0] m_tdata,
  // parallel, degenerate
  output logic [1:0]   m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data
);

  logic        ce;
  logic [31:0] eps;
  side_t       in_side;
  logic        f_valid, d_valid;
  div_t        f_item, d_item;
  logic [62:0] dist_sq;
  tail_t       tail;

  assign ce        = !m_tvalid || m_tready;
  assign s_tready  = ce;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= EPS_RESET;
    end else if (cfg_valid) begin
      eps <= cfg_data;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_side.o1[k] = s_tdata[32*k +: 32];
      in_side.d1[k] = s_tdata[96 + 18*k +: 18];
      in_side.o2[k] = s_tdata[150 + 32*k +: 32];
      in_side.d2[k] = s_tdata[246 + 18*k +: 18];
    end
  end

  llcp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (s_tvalid),
    .in_side   (in_side),
    .eps       (eps),
    .out_valid (f_valid),
    .out_item  (f_item)
  );

  llcp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (f_valid),
    .in_item   (f_item),
    .out_valid (d_valid),
    .out_item  (d_item)
  );

  llcp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (d_valid),
    .in_item   (d_item),
    .out_valid (m_tvalid),
    .dist_sq   (dist_sq),
    .out_tail  (tail)
  );

  assign m_tdata = {1'b0, tail.c2[2], tail.c2[1], tail.c2[0],
                    tail.c1[2], tail.c1[1], tail.c1[0],
                    tail.offset2, tail.offset1, dist_sq};
  assign m_tuser = {tail.degen, tail.par};

endmodule

/* src/llcp_checker.sv */
// ----------------------------------------------------------------------------
// llcp_sva
// Port-level checks on the closest point block, bound to the top level.
// ----------------------------------------------------------------------------
module llcp_sva (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [303:0] s_tdata,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [319:0] m_tdata,
  input logic [1:0]   m_tuser,
  input logic         cfg_valid,
  input logic         cfg_ready,
  input logic [31:0]  cfg_data
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result item changed while stalled");

  a_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");

  a_degen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tuser[0] && (m_tdata[126:63] == '0))
    else $error("degenerate item with nonzero offsets");

  a_par: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata[126:95] == '0))
    else $error("parallel item with nonzero offset2");

endmodule

bind line_line_closest_points_3d_top llcp_sva u_chk (.*);

/* sim/llcp_checker.sv */
// ----------------------------------------------------------------------------
// llcp_checker
// Watches the input, result and configuration channels of the line-line
// closest point block. Predicts each result from the accepted line pair and
// the current threshold, then compares every result field by field.
// ----------------------------------------------------------------------------
module llcp_checker import llcp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [303:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [319:0] m_tdata,
  input  logic [1:0]   m_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [31:0]  cfg_data,
  output int           fails,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [62:0]      dist_sq;
    logic [31:0]      off1;
    logic [31:0]      off2;
    logic [2:0][31:0] c1;
    logic [2:0][31:0] c2;
    logic             par;
    logic             degen;
  } closest_t;

  closest_t    closest_q[$];
  logic [31:0] eps;

  function automatic longint sat_word(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // signed num * 2^F / den, toward zero, saturated
  function automatic longint line_offset(logic signed [127:0] num, logic [127:0] den);
    logic [127:0] mag;
    logic [127:0] quo;
    logic         neg;
    neg = num[127];
    mag = neg ? -num : num;
    quo = (mag << FRAC_BITS) / den;
    if (neg) begin
      if (quo >= 128'h8000_0000) return -64'sd2147483648;
      return -longint'(quo[63:0]);
    end
    if (quo > 128'h7FFF_FFFF) return 64'sd2147483647;
    return longint'(quo[63:0]);
  endfunction

  function automatic closest_t predict_closest(logic [303:0] d, logic [31:0] thr_reg);
    closest_t             r;
    longint               o1[3], d1[3], o2[3], d2[3], df[3];
    longint               a00, a11, p, b0, qd, s, t, w;
    logic signed [127:0]  x, y, det, thr, sum, mg;
    a00 = 0; a11 = 0; p = 0; b0 = 0; qd = 0; s = 0; t = 0;
    r.par = 0;
    r.degen = 0;
    for (int k = 0; k < 3; k++) begin
      o1[k] = $signed(d[32*k +: 32]);
      d1[k] = $signed(d[96 + 18*k +: 18]);
      o2[k] = $signed(d[150 + 32*k +: 32]);
      d2[k] = $signed(d[246 + 18*k +: 18]);
      df[k] = o1[k] - o2[k];
    end
    for (int k = 0; k < 3; k++) begin
      a00 += d1[k] * d1[k];
      a11 += d2[k] * d2[k];
      p   += d1[k] * d2[k];
      b0  += df[k] * d1[k];
      qd  += df[k] * d2[k];
    end
    x = a00;
    x = x * a11;
    y = p;
    y = y * y;
    det = (x < y) ? y - x : x - y;
    if (a00 == 0) begin
      r.degen = 1;
      r.par = 1;
    end else begin
      thr = {96'b0, thr_reg};
      thr = thr << (2 * FRAC_BITS);
      if (det == 0 || det < thr) begin
        r.par = 1;
        x = b0;
        s = line_offset(-x, a00);
      end else begin
        x = p;  x = x * qd;
        y = a11; y = y * b0;
        s = line_offset(x - y, det);
        x = a00; x = x * qd;
        y = p;  y = y * b0;
        t = line_offset(x - y, det);
      end
    end
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      w = df[k] * (64'sd1 <<< FRAC_BITS) + d1[k] * s - d2[k] * t;
      mg = (w < 0) ? -w : w;
      sum = sum + mg * mg;
    end
    sum = sum >>> (2 * FRAC_BITS);
    r.dist_sq = (sum[127:63] != 0) ? {63{1'b1}} : sum[62:0];
    r.off1 = s[31:0];
    r.off2 = t[31:0];
    for (int k = 0; k < 3; k++) begin
      w = sat_word(o1[k] + ((d1[k] * s) >>> FRAC_BITS));
      r.c1[k] = w[31:0];
      w = sat_word(o2[k] + ((d2[k] * t) >>> FRAC_BITS));
      r.c2[k] = w[31:0];
    end
    return r;
  endfunction

  task automatic report_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    fails++;
    if (fails <= 10)
      $display("%0t mismatch %s: expected %h got %h", $realtime, name, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    closest_t e;
    if (rst) begin
      eps <= EPS_RESET;
      closest_q.delete();
      fails = 0;
      pending = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (closest_q.size() == 0) begin
          report_field("unexpected item", 0, m_tdata[63:0]);
        end else begin
          e = closest_q.pop_front();
          if (m_tdata[62:0] != e.dist_sq) report_field("dist_sq", e.dist_sq, m_tdata[62:0]);
          if (m_tdata[94:63] != e.off1) report_field("offset1", e.off1, m_tdata[94:63]);
          if (m_tdata[126:95] != e.off2) report_field("offset2", e.off2, m_tdata[126:95]);
          for (int k = 0; k < 3; k++) begin
            if (m_tdata[127 + 32*k +: 32] != e.c1[k])
              report_field($sformatf("closest1[%0d]", k), e.c1[k], m_tdata[127 + 32*k +: 32]);
            if (m_tdata[223 + 32*k +: 32] != e.c2[k])
              report_field($sformatf("closest2[%0d]", k), e.c2[k], m_tdata[223 + 32*k +: 32]);
          end
          if (m_tuser[0] != e.par) report_field("parallel", e.par, m_tuser[0]);
          if (m_tuser[1] != e.degen) report_field("degenerate", e.degen, m_tuser[1]);
        end
      end
      if (s_tvalid && s_tready) closest_q.push_back(predict_closest(s_tdata, eps));
      if (cfg_valid && cfg_ready) eps <= cfg_data;
      pending = closest_q.size();
    end
  end

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives line pairs and threshold writes into the closest point block with
// random idling on both channels; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module testbench import llcp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [303:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [319:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [31:0]  cfg_data = '0;
  int           fails;
  int           pending;
  bit           no_idle = 0;
  bit           hold_req = 0;

  line_line_closest_points_3d_top dut (.*);

  llcp_checker checker_i (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic logic [303:0] pack_lines(logic [2:0][31:0] o1, logic [2:0][17:0] d1,
                                              logic [2:0][31:0] o2, logic [2:0][17:0] d2);
    logic [303:0] d;
    d = '0;
    for (int k = 0; k < 3; k++) begin
      d[32*k +: 32]       = o1[k];
      d[96 + 18*k +: 18]  = d1[k];
      d[150 + 32*k +: 32] = o2[k];
      d[246 + 18*k +: 18] = d2[k];
    end
    return d;
  endfunction

  function automatic logic [31:0] rand_origin();
    if ($urandom_range(0, 9) < 7) return 32'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
    return $urandom;
  endfunction

  function automatic logic [17:0] rand_dir();
    if ($urandom_range(0, 4) == 0) return 18'($urandom);
    return 18'($signed($urandom_range(0, 131072)) - 65536);
  endfunction

  function automatic logic [303:0] rand_lines();
    logic [2:0][31:0] o1, o2;
    logic [2:0][17:0] d1, d2;
    int               mode;
    mode = $urandom_range(0, 19);
    for (int k = 0; k < 3; k++) begin
      o1[k] = rand_origin();
      o2[k] = rand_origin();
      d1[k] = rand_dir();
      d2[k] = rand_dir();
    end
    if (mode < 4) begin
      // near parallel: second direction follows the first or its negation
      for (int k = 0; k < 3; k++)
        d2[k] = (mode < 2) ? d1[k] + 18'($urandom_range(0, 6)) - 18'd3 : -d1[k];
    end else if (mode == 4) begin
      d1 = '0;
    end else if (mode == 5) begin
      d2 = '0;
    end
    return pack_lines(o1, d1, o2, d2);
  endfunction

  task automatic send_lines(logic [303:0] d);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic write_eps(logic [31:0] v);
    @(negedge clk);
    s_tvalid <= 0;
    wait (pending == 0);
    repeat (60) @(negedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // receiver
  initial begin
    int w;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 0;
        repeat (400) @(negedge clk);
        hold_req = 0;
      end
      w = no_idle ? 0 : $urandom_range(0, 18);
      if (w > 0) begin
        m_tready <= 0;
        repeat (w) @(negedge clk);
      end
      m_tready <= 1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [2:0][31:0] o1, o2;
    logic [2:0][17:0] d1, d2;
    logic [31:0]      eps_set[6];
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // extremes, degenerate and parallel pairs
    o1 = '0; o2 = '0; d1 = '0; d2 = '0;
    send_lines(pack_lines(o1, d1, o2, d2));
    o1 = {3{32'h7FFF_FFFF}}; o2 = {3{32'h8000_0000}};
    d1 = {3{18'h1FFFF}}; d2 = {3{18'h20000}};
    send_lines(pack_lines(o1, d1, o2, d2));
    send_lines(pack_lines(o2, d2, o1, d1));
    d1 = {18'd0, 18'd0, 18'h10000}; d2 = {18'd0, 18'h10000, 18'd0};
    send_lines(pack_lines(o1, d1, o2, d2));
    o1 = {32'h0003_0000, 32'h0002_0000, 32'h0001_0000}; o2 = '0;
    send_lines(pack_lines(o1, d1, o2, d2));
    send_lines(pack_lines(o1, d1, o2, d1));
    send_lines(pack_lines(o1, '0, o2, d2));
    send_lines(pack_lines(o1, d1, o2, '0));
    d1 = {3{18'h30000}}; d2 = {18'h0FFFF, 18'h30000, 18'h10000};
    send_lines(pack_lines(o1, d1, o2, d2));
    d1 = {3{18'h3FFFF}}; d2 = {18'h00001, 18'h3FFFF, 18'h00001};
    send_lines(pack_lines(o1, d1, o2, d2));
    d1 = {18'h2AAAA, 18'h15555, 18'h0F0F0}; d2 = {18'h15555, 18'h2AAAA, 18'h30F0F};
    send_lines(pack_lines({3{32'hAAAA_AAAA}}, d1, {3{32'h5555_5555}}, d2));
    send_lines(pack_lines({3{32'h8000_0000}}, d1, {3{32'h7FFF_FFFF}}, d2));
    send_lines(pack_lines({3{32'h7FFF_FFFF}}, {3{18'h10000}}, '0, {3{18'h10000}}));

    eps_set[0] = EPS_RESET;
    eps_set[1] = 32'd0;
    eps_set[2] = 32'hFFFF_FFFF;
    eps_set[3] = $urandom;
    eps_set[4] = EPS_RESET;
    eps_set[5] = $urandom_range(0, 1000);
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) write_eps(eps_set[ph]);
      no_idle = (ph % 2 == 1);
      for (int i = 0; i < 290; i++) begin
        if (ph == 3 && i == 20) hold_req = 1;
        send_lines(rand_lines());
      end
    end

    @(negedge clk);
    s_tvalid <= 0;
    wait (pending == 0);
    repeat (100) @(negedge clk);
    if (fails == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

/* line_line_closest_points_3d_top.f */
src/llcp_pkg.sv
src/llcp_front.sv
src/llcp_div.sv
src/llcp_back.sv
src/line_line_closest_points_3d_top.sv
src/llcp_checker.sv
sim/llcp_checker.sv
sim/testbench.sv
